// ===== hw/rtl/reed_solomon_systematic_encoder_core_assert.svh =====
// assertion macros for the reed-solomon encoder checker
// expects clk and rst_n in the scope where a macro is used
`ifndef REED_SOLOMON_SYSTEMATIC_ENCODER_CORE_ASSERT_SVH
`define REED_SOLOMON_SYSTEMATIC_ENCODER_CORE_ASSERT_SVH

// same-cycle implication
`define RSE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rse check failed: same-cycle rule");

// next-cycle implication
`define RSE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rse check failed: next-cycle rule");

`endif

// ===== hw/rtl/rse_pkg.sv =====
// shared types, constants and field arithmetic for the reed-solomon encoder
// no dependencies
`default_nettype none

package rse_pkg;

    localparam int SYMBOL_BITS      = 8;
    localparam int MAX_PARITY_PAIRS = 8;
    localparam int MAX_STAGES       = 2 * MAX_PARITY_PAIRS;
    localparam int STAGE_W          = $clog2(MAX_STAGES + 1);

    // register indexes on the configuration port
    localparam logic [1:0] REG_FIELD_POLY   = 2'd0;
    localparam logic [1:0] REG_ROOT_ELEMENT = 2'd1;
    localparam logic [1:0] REG_PARITY_PAIRS = 2'd2;

    typedef logic [SYMBOL_BITS-1:0] sym_t;
    typedef logic [STAGE_W-1:0]     stage_cnt_t;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic shift;     // parity register advances one step
        logic clear;     // parity register to zero
        sym_t fb;        // feedback symbol, zero while unloading
        logic gen_init;  // generator coefficients to zero
        logic gen_step;  // multiply generator by (1 + root x)
        sym_t root;      // current generator root
        sym_t red;       // reduction polynomial without the x^m term
    } cell_ctrl_t;

    // polynomial-basis multiply, shift and add
    function automatic sym_t gf_mul(sym_t a, sym_t b, sym_t red);
        sym_t acc;
        sym_t aa;
        acc = '0;
        aa  = a;
        for (int i = 0; i < SYMBOL_BITS; i++)
        begin
            if (b[i])
                acc = acc ^ aa;
            if (aa[SYMBOL_BITS-1])
                aa = sym_t'(aa << 1) ^ red;
            else
                aa = sym_t'(aa << 1);
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rse_cell.sv =====
// one cell of the encoder chain: a parity stage and one generator coefficient
// depends on rse_pkg
`default_nettype none

module rse_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  rse_pkg::cell_ctrl_t ctrl,
    input  rse_pkg::sym_t      right_stage,   // parity stage of the next cell
    input  rse_pkg::sym_t      left_coeff,    // coefficient of the previous cell
    output rse_pkg::sym_t      stage,
    output rse_pkg::sym_t      coeff
);
    import rse_pkg::*;

    sym_t stage_reg, stage_next;
    sym_t coeff_reg, coeff_next;

    always_comb
    begin
        stage_next = stage_reg;
        if (ctrl.clear)
            stage_next = '0;
        else if (ctrl.shift)
            stage_next = right_stage ^ gf_mul(ctrl.fb, coeff_reg, ctrl.red);
    end

    // reversed generator: p_new[k] = p[k] ^ root * p[k-1]
    always_comb
    begin
        coeff_next = coeff_reg;
        if (ctrl.gen_init)
            coeff_next = '0;
        else if (ctrl.gen_step)
            coeff_next = coeff_reg ^ gf_mul(ctrl.root, left_coeff, ctrl.red);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
            coeff_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
            coeff_reg <= coeff_next;
        end
    end

    assign stage = stage_reg;
    assign coeff = coeff_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rse_gen_ctrl.sv =====
// sequencer for the generator build: steps the root through its powers
// depends on rse_pkg
`default_nettype none

module rse_gen_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  rse_pkg::sym_t       red,
    input  rse_pkg::sym_t       root_element,
    input  rse_pkg::stage_cnt_t stage_cnt,
    output logic                busy,
    output rse_pkg::sym_t       root
);
    import rse_pkg::*;

    logic       busy_reg, busy_next;
    sym_t       root_reg, root_next;
    stage_cnt_t iter_reg, iter_next;

    always_comb
    begin
        busy_next = busy_reg;
        root_next = root_reg;
        iter_next = iter_reg;
        if (start)
        begin
            busy_next = 1'b1;
            root_next = sym_t'(1);
            iter_next = '0;
        end
        else if (busy_reg)
        begin
            root_next = gf_mul(root_reg, root_element, red);
            iter_next = iter_reg + stage_cnt_t'(1);
            if (iter_reg == stage_cnt - stage_cnt_t'(1))
                busy_next = 1'b0;
        end
    end

    // reset starts a build for the reset configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            root_reg <= sym_t'(1);
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            root_reg <= root_next;
            iter_reg <= iter_next;
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/reed_solomon_systematic_encoder_core.sv =====
// top level of the systematic reed-solomon encoder
// depends on rse_pkg, rse_cell, rse_gen_ctrl
//
//  channel   dir   handshake          payload
//  s_axis    in    tvalid/tready      tdata[7:0] data_byte, tlast last_byte
//  m_axis    out   tvalid/tready      tdata[7:0] out_byte, tuser is_parity, tlast last_out
//  apb       in    psel/penable       regs 0x0 field_poly, 0x4 root_element, 0x8 parity_pairs
//
//  message symbols go through at one transfer per cycle while tready is high; the parity
//  chain updates in parallel; after a last symbol 2t parity symbols follow, input held off
//  after reset and after each register write the generator is built, tready low
//  one output register parts the two sides; output stalls hold the input through tready
`default_nettype none

module reed_solomon_systematic_encoder_core (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tlast,
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tuser,    // [0] is_parity
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rse_pkg::*;

    // configuration registers
    logic [8:0] field_poly_reg;
    logic [7:0] root_element_reg;
    logic [3:0] parity_pairs_reg;

    logic       cfg_write;
    logic       cfg_hit;      // write to a register in the list
    logic [1:0] cfg_idx;

    assign pready    = 1'b1;
    assign cfg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_hit   = cfg_write && (cfg_idx == REG_FIELD_POLY ||
                                     cfg_idx == REG_ROOT_ELEMENT ||
                                     cfg_idx == REG_PARITY_PAIRS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_poly_reg   <= 9'd285;
            root_element_reg <= 8'd2;
            parity_pairs_reg <= 4'd8;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_FIELD_POLY:   field_poly_reg   <= pwdata[8:0];
                REG_ROOT_ELEMENT: root_element_reg <= pwdata[7:0];
                REG_PARITY_PAIRS: parity_pairs_reg <= pwdata[3:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_FIELD_POLY:   prdata = 32'(field_poly_reg);
            REG_ROOT_ELEMENT: prdata = 32'(root_element_reg);
            REG_PARITY_PAIRS: prdata = 32'(parity_pairs_reg);
            default:          prdata = '0;
        endcase
    end

    // effective t clamped to 1..MAX_PARITY_PAIRS, parity length n = 2t
    stage_cnt_t stage_cnt;
    always_comb
    begin
        if (parity_pairs_reg == 4'd0)
            stage_cnt = stage_cnt_t'(2);
        else if (int'(parity_pairs_reg) > MAX_PARITY_PAIRS)
            stage_cnt = stage_cnt_t'(MAX_STAGES);
        else
            stage_cnt = stage_cnt_t'({parity_pairs_reg, 1'b0});
    end

    // field arithmetic operands, masked to the symbol width
    sym_t red;
    sym_t root_el;
    sym_t data_sym;
    assign red      = sym_t'(field_poly_reg[SYMBOL_BITS-1:0]);
    assign root_el  = sym_t'(root_element_reg[SYMBOL_BITS-1:0]);
    assign data_sym = sym_t'(s_tdata[SYMBOL_BITS-1:0]);

    // generator build sequencer
    logic gen_busy;
    sym_t gen_root;

    rse_gen_ctrl u_gen_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (cfg_hit),
        .red          (red),
        .root_element (root_el),
        .stage_cnt    (stage_cnt),
        .busy         (gen_busy),
        .root         (gen_root)
    );

    // output register and parity unload count
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg,  out_byte_next;
    logic       out_par_reg,   out_par_next;
    logic       out_last_reg,  out_last_next;
    stage_cnt_t drain_cnt_reg, drain_cnt_next;

    logic out_free;
    logic in_fire;
    logic drain_step;

    sym_t stage_w [MAX_STAGES];
    sym_t coeff_w [MAX_STAGES];

    assign out_free   = !out_valid_reg || m_tready;
    // no new message symbol while parity is still being unloaded or taps are built
    assign s_tready   = out_free && (drain_cnt_reg == '0) && !gen_busy;
    assign in_fire    = s_tvalid && s_tready;
    assign drain_step = (drain_cnt_reg != '0) && out_free;

    // chain control: unloading shifts with zero feedback, which also clears the chain
    cell_ctrl_t ctrl;
    always_comb
    begin
        ctrl.shift    = in_fire || drain_step;
        ctrl.clear    = cfg_hit;
        ctrl.fb       = in_fire ? (data_sym ^ stage_w[0]) : '0;
        ctrl.gen_init = cfg_hit;
        ctrl.gen_step = gen_busy;
        ctrl.root     = gen_root;
        ctrl.red      = red;
    end

    // cell k holds parity stage k and coefficient k+1 of the reversed generator,
    // so its tap is g[n-1-k] for any n and the cells past n stay zero
    for (genvar k = 0; k < MAX_STAGES; k++)
    begin : g_cell
        sym_t right_stage;
        sym_t left_coeff;

        if (k == MAX_STAGES - 1)
        begin : g_tail
            assign right_stage = '0;
        end
        else
        begin : g_body
            assign right_stage = stage_w[k+1];
        end

        // coefficient zero of the reversed generator is always one
        if (k == 0)
        begin : g_head
            assign left_coeff = sym_t'(1);
        end
        else
        begin : g_link
            assign left_coeff = coeff_w[k-1];
        end

        rse_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .right_stage (right_stage),
            .left_coeff  (left_coeff),
            .stage       (stage_w[k]),
            .coeff       (coeff_w[k])
        );
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_par_next   = out_par_reg;
        out_last_next  = out_last_reg;
        drain_cnt_next = drain_cnt_reg;
        priority if (cfg_hit)
        begin
            out_valid_next = 1'b0;
            drain_cnt_next = '0;
        end
        else if (in_fire)
        begin
            // message symbol passes through; a last symbol arms the parity unload
            out_valid_next = 1'b1;
            out_byte_next  = 8'(data_sym);
            out_par_next   = 1'b0;
            out_last_next  = 1'b0;
            if (s_tlast)
                drain_cnt_next = stage_cnt;
        end
        else if (drain_step)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = 8'(stage_w[0]);
            out_par_next   = 1'b1;
            out_last_next  = (drain_cnt_reg == stage_cnt_t'(1));
            drain_cnt_next = drain_cnt_reg - stage_cnt_t'(1);
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            drain_cnt_reg <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            drain_cnt_reg <= drain_cnt_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_par_reg  <= out_par_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_par_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rse_checker.sv =====
// port-level checks for the reed-solomon encoder, bound to the top level
// depends on rse_pkg and reed_solomon_systematic_encoder_core_assert.svh
`default_nettype none

`include "reed_solomon_systematic_encoder_core_assert.svh"

module rse_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tuser,
    input logic        m_tlast,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [3:0]  paddr,
    input logic        pready
);
    import rse_pkg::*;

    logic cfg_write;
    logic cfg_hit;

    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_hit   = cfg_write && (paddr[3:2] == REG_FIELD_POLY ||
                                     paddr[3:2] == REG_ROOT_ELEMENT ||
                                     paddr[3:2] == REG_PARITY_PAIRS);

    // a stalled result holds
    `RSE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready && !cfg_write,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // the codeword ends on a parity symbol
    `RSE_ASSERT_NOW(a_last_is_parity, m_tvalid && m_tlast, m_tuser)

    // no message symbol is taken while parity is still owed
    `RSE_ASSERT_NOW(a_no_input_mid_parity, m_tvalid && m_tuser && !m_tlast, !s_tready)

    // parity symbols follow each other without a gap once taken
    `RSE_ASSERT_NEXT(a_parity_run, m_tvalid && m_tready && m_tuser && !m_tlast && !cfg_write,
        m_tvalid && m_tuser)

    // a register write rebuilds the generator before input resumes
    `RSE_ASSERT_NEXT(a_cfg_holds_input, cfg_hit, !s_tready)

endmodule

bind reed_solomon_systematic_encoder_core rse_checker u_rse_checker (.*);

`default_nettype wire
